// ===== src/flex_sensor_bend_classifier_assert.svh =====
`ifndef FLEX_SENSOR_BEND_CLASSIFIER_ASSERT_SVH
`define FLEX_SENSOR_BEND_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define FSBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fsbc: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define FSBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fsbc: next-cycle check failed");

`endif

// ===== src/fsbc_pkg.sv =====
package fsbc_pkg;

    localparam int ADC_FULL_SCALE    = 4095;
    localparam int REF_MILLIVOLTS    = 3100;
    localparam int SUPPLY_MILLIVOLTS = 3300;
    localparam int NUM_SENSORS       = 2;

    localparam int SENSOR_W = 1;
    localparam int RAW_W    = 12;
    localparam int CFG_W    = 20;
    localparam int THR_W    = 17;
    localparam int RES_W    = 24;
    localparam int FRAC_W   = 16;
    localparam int CIDX_W   = 2;

    localparam logic [THR_W-1:0] Q_ONE   = 17'h10000;
    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

    localparam logic [CFG_W-1:0] DIVIDER_RESET   = 20'd10000;
    localparam logic [CFG_W-1:0] FLAT_RESET      = 20'd25000;
    localparam logic [CFG_W-1:0] BENT_RESET      = 20'd100000;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 17'd32768;

    localparam int SUPPLY_FS = SUPPLY_MILLIVOLTS * ADC_FULL_SCALE;
    localparam int REF_W     = $clog2(REF_MILLIVOLTS + 1);
    localparam int DEN_W     = $clog2(SUPPLY_FS + 1);
    localparam int RR_W      = RAW_W + REF_W;
    localparam int DS_W      = ((DEN_W > RR_W) ? DEN_W : RR_W) + 1;
    localparam int P1_W      = CFG_W + RAW_W;
    localparam int NUM_W     = P1_W + REF_W;
    localparam int Q_W       = RES_W;
    localparam int DIV_W     = (DEN_W > CFG_W) ? DEN_W : CFG_W;
    localparam int DVD_W     = (NUM_W > CFG_W + FRAC_W) ? NUM_W : CFG_W + FRAC_W;
    localparam int CNT_W     = $clog2(Q_W);
    localparam int CN_W      = RES_W + 1;
    localparam int RG_W      = CFG_W + 1;

    typedef enum logic [CIDX_W-1:0] {
        REG_DIVIDER,
        REG_FLAT,
        REG_BENT,
        REG_THRESHOLD
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_RCHK,
        S_RDIV,
        S_CPREP,
        S_CCHK,
        S_CDIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic mul1;
        logic mul2;
        logic res_direct;
        logic res_div_start;
        logic res_div_load;
        logic curv_prep;
        logic curv_direct;
        logic curv_div_start;
        logic curv_div_load;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic res_direct_ok;
        logic curv_direct_ok;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== src/fsbc_if.sv =====
interface fsbc_in_if;
    import fsbc_pkg::*;
    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_index;
    logic [RAW_W-1:0]    raw_sample;

    modport source (output valid, output sensor_index, output raw_sample, input ready);
    modport sink (input valid, input sensor_index, input raw_sample, output ready);
endinterface

interface fsbc_out_if;
    import fsbc_pkg::*;
    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_id;
    logic [RES_W-1:0]    resistance_ohms;
    logic [THR_W-1:0]    curvature;
    logic                is_bent;
    logic                all_bent;

    modport source (output valid, output sensor_id, output resistance_ohms,
                    output curvature, output is_bent, output all_bent, input ready);
    modport sink (input valid, input sensor_id, input resistance_ohms,
                  input curvature, input is_bent, input all_bent, output ready);
endinterface

interface fsbc_cfg_if;
    import fsbc_pkg::*;
    logic             valid;
    logic             ready;
    t_reg_idx         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/fsbc_divider.sv =====
module fsbc_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fsbc_pkg::DVD_W-1:0]   i_dividend,
    input  logic [fsbc_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [fsbc_pkg::Q_W-1:0]     o_quotient
);
    import fsbc_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [Q_W-1:0]   r_low;
    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;
    logic [DIV_W-1:0] n_rem;

    // Restoring division, one quotient bit per cycle; the caller guarantees
    // that the quotient fits in Q_W bits.
    always_comb begin
        w_shift = {r_rem, r_low[Q_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_W'(i_dividend >> Q_W);
            r_low <= i_dividend[Q_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[Q_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule

// ===== src/fsbc_datapath.sv =====
module fsbc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fsbc_in_if.sink           i_in,
    fsbc_out_if.source        o_out,
    fsbc_cfg_if.sink          i_cfg,
    input  fsbc_pkg::t_cmd    i_cmd,
    output fsbc_pkg::t_status o_status
);
    import fsbc_pkg::*;

    logic [CFG_W-1:0]       r_div_res;
    logic [CFG_W-1:0]       r_flat;
    logic [CFG_W-1:0]       r_bent;
    logic [THR_W-1:0]       r_thr;
    logic [NUM_SENSORS-1:0] r_flags;
    logic [NUM_SENSORS-1:0] n_flags;

    logic [SENSOR_W-1:0]    r_idx;
    logic [RAW_W-1:0]       r_raw;
    logic [P1_W-1:0]        r_prod1;
    logic [RR_W-1:0]        r_rawref;
    logic [NUM_W-1:0]       r_num;
    logic signed [DS_W-1:0] r_den;
    logic [RES_W-1:0]       r_res;
    logic signed [CN_W-1:0] r_cnum;
    logic signed [RG_W-1:0] r_crange;
    logic [THR_W-1:0]       r_curv;

    logic                   r_out_valid;
    logic [SENSOR_W-1:0]    r_out_id;
    logic [RES_W-1:0]       r_out_res;
    logic [THR_W-1:0]       r_out_curv;
    logic                   r_out_bent;
    logic                   r_out_all;

    logic                   w_accept;
    logic                   w_den_neg;
    logic [DS_W-1:0]        w_den_abs;
    logic [DS_W-2:0]        w_den_mag;
    logic [RES_W:0]         w_sent10;
    logic [RES_W-1:0]       w_sentinel;
    logic                   w_raw_full;
    logic                   w_near;
    logic                   w_ovf;
    logic [RES_W-1:0]       w_res_direct;
    logic signed [RG_W-1:0] w_range;
    logic signed [CN_W-1:0] w_cnum;
    logic signed [CN_W-1:0] w_crange_ext;
    logic                   w_czero;
    logic                   w_cfull;
    logic                   w_bent;
    logic                   w_div_start;
    logic [DVD_W-1:0]       w_dividend;
    logic [DIV_W-1:0]       w_divisor;
    logic                   w_div_busy;
    logic                   w_div_done;
    logic [Q_W-1:0]         w_quotient;
    logic [THR_W-1:0]       w_cfg_thr;

    assign w_accept    = i_in.valid && i_cmd.in_ready;
    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;
    assign w_cfg_thr   = i_cfg.data[THR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_res <= DIVIDER_RESET;
            r_flat    <= FLAT_RESET;
            r_bent    <= BENT_RESET;
            r_thr     <= THRESHOLD_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_DIVIDER:   r_div_res <= i_cfg.data;
                REG_FLAT:      r_flat    <= i_cfg.data;
                REG_BENT:      r_bent    <= i_cfg.data;
                REG_THRESHOLD: r_thr     <= (w_cfg_thr > Q_ONE) ? Q_ONE : w_cfg_thr;
            endcase
        end
    end

    always_comb begin
        w_den_neg  = r_den[DS_W-1];
        w_den_abs  = w_den_neg ? DS_W'(-r_den) : DS_W'(r_den);
        w_den_mag  = w_den_abs[DS_W-2:0];
        w_sent10   = (RES_W+1)'(r_bent) * (RES_W+1)'(10);
        w_sentinel = (w_sent10 > {1'b0, RES_MAX}) ? RES_MAX : w_sent10[RES_W-1:0];
        w_raw_full = (32'(r_raw) >= ADC_FULL_SCALE);
        w_near     = (32'(w_den_mag) < ADC_FULL_SCALE);
        w_ovf      = ((r_num >> Q_W) >= NUM_W'(w_den_mag));
        priority if (w_raw_full || w_near) begin
            w_res_direct = w_sentinel;
        end else if (w_den_neg) begin
            w_res_direct = '0;
        end else begin
            w_res_direct = RES_MAX;
        end
    end

    always_comb begin
        w_range      = $signed({1'b0, r_bent}) - $signed({1'b0, r_flat});
        w_cnum       = $signed({1'b0, r_res}) - $signed(CN_W'(r_flat));
        w_crange_ext = CN_W'(r_crange);
        w_czero      = (r_crange == '0) || (r_cnum <= 0);
        w_cfull      = (r_cnum >= w_crange_ext);
    end

    assign w_div_start = i_cmd.res_div_start || i_cmd.curv_div_start;
    assign w_dividend  = i_cmd.curv_div_start ? DVD_W'({r_cnum[CFG_W-1:0], FRAC_W'(0)})
                                              : DVD_W'(r_num);
    assign w_divisor   = i_cmd.curv_div_start ? DIV_W'(r_crange[CFG_W-1:0])
                                              : DIV_W'(w_den_mag);

    fsbc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= i_in.sensor_index;
            r_raw <= i_in.raw_sample;
        end
        if (i_cmd.mul1) begin
            r_prod1  <= P1_W'(r_div_res) * P1_W'(r_raw);
            r_rawref <= RR_W'(r_raw) * RR_W'(REF_MILLIVOLTS);
        end
        if (i_cmd.mul2) begin
            r_num <= NUM_W'(r_prod1) * NUM_W'(REF_MILLIVOLTS);
            r_den <= $signed(DS_W'(SUPPLY_FS)) - $signed(DS_W'(r_rawref));
        end
        if (i_cmd.res_direct) begin
            r_res <= w_res_direct;
        end else if (i_cmd.res_div_load) begin
            r_res <= w_quotient;
        end
        if (i_cmd.curv_prep) begin
            if (w_range < 0) begin
                r_crange <= -w_range;
                r_cnum   <= -w_cnum;
            end else begin
                r_crange <= w_range;
                r_cnum   <= w_cnum;
            end
        end
        if (i_cmd.curv_direct) begin
            r_curv <= w_czero ? '0 : Q_ONE;
        end else if (i_cmd.curv_div_load) begin
            r_curv <= w_quotient[THR_W-1:0];
        end
    end

    assign w_bent = (r_curv >= r_thr);

    always_comb begin
        n_flags = r_flags;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (32'(r_idx) == i) begin
                n_flags[i] = w_bent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_id   <= r_idx;
            r_out_res  <= r_res;
            r_out_curv <= r_curv;
            r_out_bent <= w_bent;
            r_out_all  <= &n_flags;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.sensor_id       = r_out_id;
    assign o_out.resistance_ohms = r_out_res;
    assign o_out.curvature       = r_out_curv;
    assign o_out.is_bent         = r_out_bent;
    assign o_out.all_bent        = r_out_all;

    always_comb begin
        o_status.in_valid       = i_in.valid;
        o_status.res_direct_ok  = w_raw_full || w_near || w_den_neg || w_ovf;
        o_status.curv_direct_ok = w_czero || w_cfull;
        o_status.div_busy       = w_div_busy;
        o_status.div_done       = w_div_done;
        o_status.out_free       = !r_out_valid || o_out.ready;
    end

endmodule

// ===== src/fsbc_ctrl.sv =====
module fsbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsbc_pkg::t_status i_status,
    output fsbc_pkg::t_cmd    o_cmd
);
    import fsbc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.in_valid) n_state = S_MUL1;
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_RCHK;
            S_RCHK: begin
                n_state = i_status.res_direct_ok ? S_CPREP : S_RDIV;
            end
            S_RDIV: begin
                if (i_status.div_done) n_state = S_CPREP;
            end
            S_CPREP: n_state = S_CCHK;
            S_CCHK: begin
                n_state = i_status.curv_direct_ok ? S_DONE : S_CDIV;
            end
            S_CDIV: begin
                if (i_status.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.in_ready = 1'b1;
            S_MUL1:  o_cmd.mul1 = 1'b1;
            S_MUL2:  o_cmd.mul2 = 1'b1;
            S_RCHK: begin
                o_cmd.res_direct    = i_status.res_direct_ok;
                o_cmd.res_div_start = !i_status.res_direct_ok;
            end
            S_RDIV:  o_cmd.res_div_load = i_status.div_done;
            S_CPREP: o_cmd.curv_prep = 1'b1;
            S_CCHK: begin
                o_cmd.curv_direct    = i_status.curv_direct_ok;
                o_cmd.curv_div_start = !i_status.curv_direct_ok;
            end
            S_CDIV:  o_cmd.curv_div_load = i_status.div_done;
            S_DONE:  o_cmd.finish = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/flex_sensor_bend_classifier.sv =====
// Flex sensor bend classifier: each input transfer carries one ADC sample and a sensor index
// and produces exactly one result transfer with the sensor resistance, the Q1.16 curvature,
// the bent flag and the AND of the latest bent flags of all sensors. One item is processed at
// a time: after acceptance the item passes the two multiply steps, then the resistance and
// the curvature, each taken directly or from the divider, into the result register, which
// is loaded once the previous result has been taken; the next item is accepted after that.
// The single shared restoring divider produces one of its 24 quotient bits per cycle and
// is used first for the resistance and then for the curvature. Configuration writes are
// accepted in every cycle and must only be issued while no item is in flight.
`include "flex_sensor_bend_classifier_assert.svh"

module flex_sensor_bend_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsbc_in_if.sink    i_in,
    fsbc_out_if.source o_out,
    fsbc_cfg_if.sink   i_cfg
);
    import fsbc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    fsbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fsbc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

    `FSBC_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready)
    `FSBC_ASSERT_NOW(a_div_start_idle, w_cmd.res_div_start || w_cmd.curv_div_start, !w_status.div_busy)
    `FSBC_ASSERT_NOW(a_curv_bound, o_out.valid, o_out.curvature <= Q_ONE)
    `FSBC_ASSERT_NEXT(a_finish_valid, w_cmd.finish, o_out.valid)

endmodule

// ===== tb/sv/flex_sensor_bend_classifier_tb.sv =====
module flex_sensor_bend_classifier_tb;
    import fsbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic [SENSOR_W-1:0] sensor;
        logic [RAW_W-1:0]    raw;
    } t_sample;

    typedef struct {
        t_reg_idx         idx;
        logic [CFG_W-1:0] data;
    } t_reg_write;

    typedef struct {
        logic [SENSOR_W-1:0] sensor_id;
        logic [RES_W-1:0]    resistance_ohms;
        logic [THR_W-1:0]    curvature;
        logic                is_bent;
        logic                all_bent;
    } t_bend_result;

    logic i_clk;
    logic i_rst_n;

    fsbc_in_if  in_bus();
    fsbc_out_if out_bus();
    fsbc_cfg_if cfg_bus();

    flex_sensor_bend_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    t_sample      pending_samples[$];
    t_reg_write   pending_writes[$];
    t_bend_result expected_results[$];

    logic [CFG_W-1:0]       div_ohms;
    logic [CFG_W-1:0]       flat_ohms;
    logic [CFG_W-1:0]       bent_ohms;
    logic [THR_W-1:0]       thr_q;
    logic [NUM_SENSORS-1:0] bent_flags;

    int in_hold     = 0;
    int out_hold    = 0;
    bit gaps_on     = 1'b1;
    int fail_count  = 0;
    int quiet_cycles = 0;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    // Resistance from the divider equation, then curvature against the flat/bent range.
    function automatic t_bend_result classify_sample(input logic [SENSOR_W-1:0] sensor,
                                                     input logic [RAW_W-1:0] raw);
        t_bend_result res;
        longint sentinel;
        longint den;
        longint mag;
        longint r;
        longint span;
        longint offset;
        longint c;
        sentinel = longint'(bent_ohms) * 10;
        if (sentinel > longint'(RES_MAX)) sentinel = longint'(RES_MAX);
        den = longint'(SUPPLY_MILLIVOLTS) * longint'(ADC_FULL_SCALE)
            - longint'(raw) * longint'(REF_MILLIVOLTS);
        mag = (den < 0) ? -den : den;
        if (longint'(raw) >= longint'(ADC_FULL_SCALE)) begin
            r = sentinel;
        end else if (mag < longint'(ADC_FULL_SCALE)) begin
            r = sentinel;
        end else if (den < 0) begin
            r = 0;
        end else begin
            r = (longint'(div_ohms) * longint'(raw) * longint'(REF_MILLIVOLTS)) / den;
            if (r > longint'(RES_MAX)) r = longint'(RES_MAX);
        end
        span   = longint'(bent_ohms) - longint'(flat_ohms);
        offset = r - longint'(flat_ohms);
        if (span == 0) begin
            c = 0;
        end else begin
            if (span < 0) begin
                span   = -span;
                offset = -offset;
            end
            if (offset <= 0) c = 0;
            else if (offset >= span) c = longint'(Q_ONE);
            else c = (offset * longint'(Q_ONE)) / span;
        end
        res.sensor_id       = sensor;
        res.resistance_ohms = r[RES_W-1:0];
        res.curvature       = c[THR_W-1:0];
        res.is_bent         = (c >= longint'(thr_q));
        res.all_bent        = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            in_hold = 0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (in_hold > 0) begin
                in_hold--;
                in_bus.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                t_sample cur;
                cur = pending_samples.pop_front();
                in_bus.valid        <= 1'b1;
                in_bus.sensor_index <= cur.sensor;
                in_bus.raw_sample   <= cur.raw;
                if (gaps_on && $urandom_range(0, 9) == 0) in_hold = $urandom_range(1, 14);
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_bus.valid <= 1'b0;
        end else if (!cfg_bus.valid || cfg_bus.ready) begin
            if (pending_writes.size() > 0) begin
                t_reg_write wr;
                wr = pending_writes.pop_front();
                cfg_bus.valid <= 1'b1;
                cfg_bus.index <= wr.idx;
                cfg_bus.data  <= wr.data;
            end else begin
                cfg_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_hold--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 11) == 0) out_hold = $urandom_range(1, 14);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_bend_result want;
        logic [THR_W-1:0] thr_raw;
        bit moved;
        if (!i_rst_n) begin
            div_ohms     = DIVIDER_RESET;
            flat_ohms    = FLAT_RESET;
            bent_ohms    = BENT_RESET;
            thr_q        = THRESHOLD_RESET;
            bent_flags   = '0;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (out_bus.valid && out_bus.ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with no sample pending");
                end else begin
                    want = expected_results.pop_front();
                    if (out_bus.sensor_id !== want.sensor_id)
                        report_mismatch($sformatf("sensor_id got %0d expected %0d",
                                                  out_bus.sensor_id, want.sensor_id));
                    if (out_bus.resistance_ohms !== want.resistance_ohms)
                        report_mismatch($sformatf("resistance_ohms got %0d expected %0d",
                                                  out_bus.resistance_ohms,
                                                  want.resistance_ohms));
                    if (out_bus.curvature !== want.curvature)
                        report_mismatch($sformatf("curvature got %0d expected %0d",
                                                  out_bus.curvature, want.curvature));
                    if (out_bus.is_bent !== want.is_bent)
                        report_mismatch($sformatf("is_bent got %0d expected %0d",
                                                  out_bus.is_bent, want.is_bent));
                    if (out_bus.all_bent !== want.all_bent)
                        report_mismatch($sformatf("all_bent got %0d expected %0d",
                                                  out_bus.all_bent, want.all_bent));
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved = 1'b1;
                case (cfg_bus.index)
                    REG_DIVIDER: div_ohms  = cfg_bus.data;
                    REG_FLAT:    flat_ohms = cfg_bus.data;
                    REG_BENT:    bent_ohms = cfg_bus.data;
                    REG_THRESHOLD: begin
                        thr_raw = cfg_bus.data[THR_W-1:0];
                        thr_q   = (thr_raw > Q_ONE) ? Q_ONE : thr_raw;
                    end
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                moved = 1'b1;
                want = classify_sample(in_bus.sensor_index, in_bus.raw_sample);
                if (int'(in_bus.sensor_index) < NUM_SENSORS)
                    bent_flags[in_bus.sensor_index] = want.is_bent;
                want.all_bent = &bent_flags;
                expected_results.push_back(want);
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    task automatic push_sample(input logic [SENSOR_W-1:0] sensor, input logic [RAW_W-1:0] raw);
        t_sample s;
        s.sensor = sensor;
        s.raw    = raw;
        pending_samples.push_back(s);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || pending_writes.size() != 0 || in_bus.valid
               || cfg_bus.valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] f,
                             input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] t,
                             input int n);
        t_reg_write wr;
        logic [RAW_W-1:0] raw;
        wr.idx = REG_DIVIDER;   wr.data = d; pending_writes.push_back(wr);
        wr.idx = REG_FLAT;      wr.data = f; pending_writes.push_back(wr);
        wr.idx = REG_BENT;      wr.data = b; pending_writes.push_back(wr);
        wr.idx = REG_THRESHOLD; wr.data = t; pending_writes.push_back(wr);
        do @(negedge i_clk);
        while (pending_writes.size() != 0 || cfg_bus.valid);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: raw = RAW_W'(ADC_FULL_SCALE);
                1: raw = RAW_W'($urandom_range(3900, 4094));
                2: raw = RAW_W'($urandom_range(0, 63));
                default: raw = RAW_W'($urandom_range(0, 4095));
            endcase
            push_sample(SENSOR_W'($urandom_range(0, 1)), raw);
        end
        wait_idle();
    endtask

    initial begin
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] f;
        logic [CFG_W-1:0] b;
        logic [CFG_W-1:0] t;
        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.sensor_index = '0;
        in_bus.raw_sample   = '0;
        out_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_DIVIDER;
        cfg_bus.data        = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Power-on settings: both sensors flat, then full-scale on both, then one released, then a mix of levels.
        push_sample(1'b0, 12'd0);
        push_sample(1'b1, 12'd0);
        push_sample(1'b0, 12'd4095);
        push_sample(1'b1, 12'd4095);
        push_sample(1'b0, 12'd4094);
        push_sample(1'b1, 12'd2048);
        push_sample(1'b0, 12'd1);
        push_sample(1'b1, 12'hAAA);
        push_sample(1'b0, 12'h555);
        push_sample(1'b1, 12'd3900);
        push_sample(1'b0, 12'd3500);
        push_sample(1'b1, 12'd4000);
        push_sample(1'b0, 12'd4095);
        push_sample(1'b1, 12'd0);
        wait_idle();

        // Zero range, then maximum divider with a threshold that clamps to one.
        run_phase(20'd0, 20'd0, 20'd0, 20'd0, 120);
        run_phase(20'hFFFFF, 20'd0, 20'hFFFFF, 20'hFFFFF, 120);
        // Inverted range and an equal nonzero range.
        run_phase(20'd10000, 20'd1000000, 20'd1000, 20'd20000, 150);
        run_phase(20'd47000, 20'd30000, 20'd30000, 20'd65536, 100);
        run_phase(20'd10000, 20'd25000, 20'd100000, 20'd65537, 100);

        for (int p = 0; p < 7; p++) begin
            d = CFG_W'($urandom_range(1000, 100000));
            f = CFG_W'($urandom_range(0, 150000));
            if ($urandom_range(0, 1)) b = f + CFG_W'($urandom_range(1, 850000));
            else b = CFG_W'($urandom_range(0, f));
            if ($urandom_range(0, 3) == 0) t = CFG_W'($urandom());
            else t = CFG_W'($urandom_range(0, 65536));
            if (p == 6) gaps_on = 1'b0;
            run_phase(d, f, b, t, (p == 6) ? 160 : 150);
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
